### sv/popularity_palette_quantizer_defines.svh
// Assertion macros shared by the palette quantizer RTL.
`ifndef POPULARITY_PALETTE_QUANTIZER_DEFINES_SVH
`define POPULARITY_PALETTE_QUANTIZER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ppq_pkg.sv
// Package with the types and constants of the palette quantizer.
package ppq_pkg;

  localparam int NUM_COLORS_DEF   = 256;
  localparam int PALETTE_SIZE_DEF = 16;
  localparam int COUNT_WIDTH_DEF  = 20;

  localparam int PIX_W  = 8;
  localparam int SLOT_W = 4;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_COUNT   = 2'd1,
    REQ_PALETTE = 2'd2,
    REQ_MAP     = 2'd3
  } req_t;

  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_MAP     = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COPY,
    ST_EMIT
  } state_t;

endpackage

### sv/ppq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ppq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/popularity_palette_quantizer.sv
// Top level of the popularity palette quantizer: histogram, palette builder and pixel mapper.
//
// The block collects a histogram of pixel values, builds a palette of the
// PALETTE_SIZE most frequent values, and maps pixels to palette slots. A
// request is taken at a clock edge where start is high and busy is low.
// Clear, count and map requests are taken one per cycle, back to back, while
// busy is low, and never raise busy. A clear takes effect at once: each
// histogram bin has a valid flag that the clear drops, so there is no
// clearing sweep. A count does a read-modify-write of its bin in the
// histogram RAM; the write lands in the cycle after the request, and a count
// of the same bin in the next cycle picks up the new value through a
// forwarding register. A map request's result passes through the stage-one
// group registers and then the output register to the output ports. A
// palette request walks all NUM_COLORS bins through the single read port of
// the histogram RAM, one bin per cycle, inserting each into a sorted top list,
// while busy stays high; the PALETTE_SIZE entries come out on consecutive
// cycles, slot 0 first. Each result is on the out_ ports for exactly one
// cycle, marked by out_valid; the receiver cannot stall the block, so it must
// take every result in the cycle it is shown. The histogram itself is left
// untouched by a palette request.
module popularity_palette_quantizer #(
  parameter int NUM_COLORS   = ppq_pkg::NUM_COLORS_DEF,
  parameter int PALETTE_SIZE = ppq_pkg::PALETTE_SIZE_DEF,
  parameter int COUNT_WIDTH  = ppq_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_req_type,
  input  logic [ppq_pkg::PIX_W-1:0]  in_pixel,
  output logic                       out_valid,
  output logic                       out_result_kind,
  output logic [ppq_pkg::PIX_W-1:0]  out_palette_color,
  output logic [ppq_pkg::SLOT_W-1:0] out_slot,
  output logic                       out_last
);

  `include "popularity_palette_quantizer_defines.svh"

  localparam int BIN_AW = $clog2(NUM_COLORS);
  localparam int PAL_AW = $clog2(PALETTE_SIZE);
  localparam int NG     = (PALETTE_SIZE + 3) / 4;

  localparam logic [BIN_AW-1:0]      BIN_LAST  = BIN_AW'(NUM_COLORS - 1);
  localparam logic [PAL_AW-1:0]      SLOT_LAST = PAL_AW'(PALETTE_SIZE - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;

  // Request decode.
  logic acc;
  logic acc_clear;
  logic acc_count;
  logic acc_palette;
  logic acc_map;
  logic pixel_ok;

  assign acc         = start && !busy;
  assign acc_clear   = acc && (in_req_type == ppq_pkg::REQ_CLEAR);
  assign acc_count   = acc && (in_req_type == ppq_pkg::REQ_COUNT);
  assign acc_palette = acc && (in_req_type == ppq_pkg::REQ_PALETTE);
  assign acc_map     = acc && (in_req_type == ppq_pkg::REQ_MAP);
  // Counts of values outside the histogram are dropped.
  assign pixel_ok    = ({1'b0, in_pixel} < 9'(NUM_COLORS));

  ppq_pkg::state_t state_r, state_nxt;

  // Histogram RAM and its bin valid flags.
  logic [NUM_COLORS-1:0]  hv_r;
  logic [BIN_AW-1:0]      ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic                   ram_we;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [BIN_AW-1:0]      rd_addr_q_r;

  // Count pipeline: the read issued at acceptance returns in the s1 cycle.
  logic                   s1_v_r;
  logic                   lw_v_r;
  logic [BIN_AW-1:0]      lw_addr_r;
  logic [COUNT_WIDTH-1:0] lw_val_r;
  logic [COUNT_WIDTH-1:0] bin_val;

  // Palette scan.
  logic                   sc_issue_r;
  logic [BIN_AW-1:0]      sc_addr_r;
  logic                   rd_pend_r;
  logic                   lst_v_r   [PALETTE_SIZE];
  logic [COUNT_WIDTH-1:0] lst_cnt_r [PALETTE_SIZE];
  logic [ppq_pkg::PIX_W-1:0] lst_col_r [PALETTE_SIZE];
  logic [PALETTE_SIZE-1:0] ins;
  logic [PALETTE_SIZE-1:0] take_new;
  logic [ppq_pkg::PIX_W-1:0] scan_col;
  logic [ppq_pkg::PIX_W-1:0] palette_r [PALETTE_SIZE];
  logic [PAL_AW-1:0]      emit_idx_r;
  logic                   emit_last;

  // Map pipeline: four-slot groups reduced in the first stage.
  logic                      m1_v_r;
  logic [ppq_pkg::PIX_W-1:0] m1_dist_r  [NG];
  logic [ppq_pkg::SLOT_W-1:0] m1_slot_r [NG];
  logic [ppq_pkg::PIX_W-1:0] m1_color_r [NG];
  logic [8:0]                g_best  [NG];
  logic [ppq_pkg::SLOT_W-1:0] g_slot [NG];
  logic [ppq_pkg::PIX_W-1:0] g_color [NG];
  logic [8:0]                f_best;
  logic [ppq_pkg::SLOT_W-1:0] f_slot;
  logic [ppq_pkg::PIX_W-1:0] f_color;

  // Output register.
  logic                       out_valid_r;
  logic                       out_kind_r;
  logic [ppq_pkg::PIX_W-1:0]  out_color_r;
  logic [ppq_pkg::SLOT_W-1:0] out_slot_r;
  logic                       out_last_r;

  assign busy              = (state_r != ppq_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_palette_color = out_color_r;
  assign out_slot          = out_slot_r;
  assign out_last          = out_last_r;

  assign ram_raddr = (state_r == ppq_pkg::ST_SCAN) ? sc_addr_r : in_pixel[BIN_AW-1:0];

  ppq_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(NUM_COLORS)
  ) u_hist_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(rd_addr_q_r),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // The bin value seen this cycle: the write from the previous cycle wins over
  // the RAM, and a bin whose flag is down reads as zero.
  always_comb begin
    if (lw_v_r && (lw_addr_r == rd_addr_q_r)) begin
      bin_val = lw_val_r;
    end else if (hv_r[rd_addr_q_r]) begin
      bin_val = ram_rdata;
    end else begin
      bin_val = '0;
    end
  end

  assign ram_we    = s1_v_r;
  assign ram_wdata = (bin_val == CNT_MAX) ? bin_val : bin_val + COUNT_WIDTH'(1);

  // The top list stays sorted, so the insertion flags rise monotonically and
  // the new bin goes in at the first raised flag. Bins arrive in increasing
  // value order, so a tie leaves the earlier, lower value ahead.
  always_comb begin
    logic prev;
    prev = 1'b0;
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      ins[i]      = !lst_v_r[i] || (bin_val > lst_cnt_r[i]);
      take_new[i] = ins[i] && !prev;
      prev        = ins[i];
    end
  end

  assign scan_col  = ppq_pkg::PIX_W'(rd_addr_q_r);
  assign emit_last = (emit_idx_r == SLOT_LAST);

  // Map stage one: distance to every slot, best of each group of four.
  always_comb begin
    logic [7:0] c;
    logic [7:0] d;
    for (int g = 0; g < NG; g++) begin
      g_best[g]  = 9'h1FF;
      g_slot[g]  = '0;
      g_color[g] = '0;
    end
    for (int k = 0; k < PALETTE_SIZE; k++) begin
      c = palette_r[k];
      d = (in_pixel > c) ? (in_pixel - c) : (c - in_pixel);
      if ({1'b0, d} < g_best[k >> 2]) begin
        g_best[k >> 2]  = {1'b0, d};
        g_slot[k >> 2]  = ppq_pkg::SLOT_W'(k);
        g_color[k >> 2] = c;
      end
    end
  end

  // Map stage two: best over the groups, lower group first on ties.
  always_comb begin
    f_best  = 9'h1FF;
    f_slot  = '0;
    f_color = '0;
    for (int g = 0; g < NG; g++) begin
      if ({1'b0, m1_dist_r[g]} < f_best) begin
        f_best  = {1'b0, m1_dist_r[g]};
        f_slot  = m1_slot_r[g];
        f_color = m1_color_r[g];
      end
    end
  end

  // Sequencer for the palette request.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppq_pkg::ST_IDLE: begin
        if (acc_palette) begin
          state_nxt = ppq_pkg::ST_SCAN;
        end
      end
      ppq_pkg::ST_SCAN: begin
        if (rd_pend_r && (rd_addr_q_r == BIN_LAST)) begin
          state_nxt = ppq_pkg::ST_COPY;
        end
      end
      ppq_pkg::ST_COPY: begin
        state_nxt = ppq_pkg::ST_EMIT;
      end
      ppq_pkg::ST_EMIT: begin
        if (emit_last) begin
          state_nxt = ppq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ppq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r        <= '0;
      s1_v_r      <= 1'b0;
      lw_v_r      <= 1'b0;
      sc_issue_r  <= 1'b0;
      rd_pend_r   <= 1'b0;
      m1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      emit_idx_r  <= '0;
      for (int i = 0; i < PALETTE_SIZE; i++) begin
        lst_v_r[i]   <= 1'b0;
        palette_r[i] <= ppq_pkg::PIX_W'(i);
      end
    end else begin
      // A clear in the same cycle as a pending write still wins.
      if (acc_clear) begin
        hv_r <= '0;
      end else if (s1_v_r) begin
        hv_r[rd_addr_q_r] <= 1'b1;
      end
      s1_v_r <= acc_count && pixel_ok;
      lw_v_r <= s1_v_r && !acc_clear;

      rd_pend_r <= (state_r == ppq_pkg::ST_SCAN) && sc_issue_r;
      if (acc_palette) begin
        sc_issue_r <= 1'b1;
        for (int i = 0; i < PALETTE_SIZE; i++) begin
          lst_v_r[i] <= 1'b0;
        end
      end else if ((state_r == ppq_pkg::ST_SCAN) && (sc_addr_r == BIN_LAST)) begin
        sc_issue_r <= 1'b0;
      end

      if (rd_pend_r) begin
        lst_v_r[0] <= 1'b1;
        for (int i = 1; i < PALETTE_SIZE; i++) begin
          if (ins[i]) begin
            lst_v_r[i] <= take_new[i] ? 1'b1 : lst_v_r[i-1];
          end
        end
      end

      if (state_r == ppq_pkg::ST_COPY) begin
        for (int i = 0; i < PALETTE_SIZE; i++) begin
          palette_r[i] <= lst_col_r[i];
        end
        emit_idx_r <= '0;
      end else if (state_r == ppq_pkg::ST_EMIT) begin
        emit_idx_r <= emit_idx_r + PAL_AW'(1);
      end

      m1_v_r      <= acc_map;
      out_valid_r <= m1_v_r || (state_r == ppq_pkg::ST_EMIT);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_addr_q_r <= ram_raddr;
    lw_addr_r   <= rd_addr_q_r;
    lw_val_r    <= ram_wdata;

    if (acc_palette) begin
      sc_addr_r <= '0;
    end else if ((state_r == ppq_pkg::ST_SCAN) && sc_issue_r && (sc_addr_r != BIN_LAST)) begin
      sc_addr_r <= sc_addr_r + BIN_AW'(1);
    end

    if (rd_pend_r) begin
      if (take_new[0]) begin
        lst_cnt_r[0] <= bin_val;
        lst_col_r[0] <= scan_col;
      end
      for (int i = 1; i < PALETTE_SIZE; i++) begin
        if (take_new[i]) begin
          lst_cnt_r[i] <= bin_val;
          lst_col_r[i] <= scan_col;
        end else if (ins[i]) begin
          lst_cnt_r[i] <= lst_cnt_r[i-1];
          lst_col_r[i] <= lst_col_r[i-1];
        end
      end
    end

    for (int g = 0; g < NG; g++) begin
      m1_dist_r[g]  <= g_best[g][7:0];
      m1_slot_r[g]  <= g_slot[g];
      m1_color_r[g] <= g_color[g];
    end

    if (state_r == ppq_pkg::ST_EMIT) begin
      out_kind_r  <= ppq_pkg::KIND_PALETTE;
      out_color_r <= palette_r[emit_idx_r];
      out_slot_r  <= ppq_pkg::SLOT_W'(emit_idx_r);
      out_last_r  <= emit_last;
    end else begin
      out_kind_r  <= ppq_pkg::KIND_MAP;
      out_color_r <= f_color;
      out_slot_r  <= f_slot;
      out_last_r  <= 1'b1;
    end
  end

  // A count write and a scan read never return in the same cycle.
  `PPQ_ASSERT_NOW(a_no_count_in_scan, s1_v_r, !rd_pend_r, "count write during palette scan")
  // A map result never collides with palette emission.
  `PPQ_ASSERT_NOW(a_map_not_in_emit, m1_v_r, state_r != ppq_pkg::ST_EMIT, "map during emission")
  // Palette entries only come from the emission state.
  `PPQ_ASSERT_NOW(a_palette_from_emit, out_valid_r && (out_kind_r == ppq_pkg::KIND_PALETTE),
    $past(state_r) == ppq_pkg::ST_EMIT, "palette entry outside emission")
  // The final slot carries the last flag and frees the block.
  `PPQ_ASSERT_NEXT(a_emit_end, (state_r == ppq_pkg::ST_EMIT) && emit_last,
    out_valid_r && out_last_r && !busy, "palette emission did not end cleanly")

endmodule
